/* rtl/uvc_pkg.sv */
package uvc_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Observation length limit and byte counter.
    localparam int unsigned        COUNT_W       = 13;
    localparam logic [COUNT_W-1:0] MAX_BYTES_RST = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_SAT     = 13'h1fff;

    // Lead byte ranges.
    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;

    // Code point limits and special characters.
    localparam logic [20:0] CP_MAX      = 21'h10ffff;
    localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;
    localparam logic [20:0] CP_LSEP     = 21'h002028;
    localparam logic [20:0] CP_PSEP     = 21'h002029;
    localparam logic [20:0] CP_BOM      = 21'h00feff;
    localparam logic [20:0] CP_CR       = 21'h00000d;
    localparam logic [20:0] CP_LF       = 21'h00000a;
    localparam logic [20:0] CP_SPACE    = 21'h000020;
    localparam logic [20:0] CP_C1_LO    = 21'h00007f;
    localparam logic [20:0] CP_C1_HI    = 21'h00009f;
    localparam logic [20:0] CP_NBSP     = 21'h0000a0;

    // Separator bytes written in the output.
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // Results one input byte can cause, and queue depth.
    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    // One result before the run_last mark is attached.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
    } t_result;

    // All results caused by one input byte.
    typedef struct packed {
        logic [2:0]                   count;
        t_result [MAX_RESULTS-1:0]    items;
    } t_job;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

/* rtl/uvc_front.sv */
module uvc_front
    import uvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in,
    input  t_queue_status       i_qstat,
    output logic                o_push,
    output t_job                o_job
);

    logic [COUNT_W-1:0] r_max_bytes;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [20:0]        r_accum, n_accum;
    logic [1:0]         r_left, n_left;
    logic [1:0]         r_slen, n_slen;
    logic               r_psp, n_psp;
    logic               r_pnl, n_pnl;
    logic               r_emitted, n_emitted;
    logic               r_failed, n_failed;
    logic [7:0]         r_held [3];
    logic [7:0]         n_held [3];

    logic               accept;
    logic               v_fail;
    logic               v_finish;
    logic               v_emit;
    logic [1:0]         v_pos;
    logic [7:0]         b;
    t_result            cand [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] cand_v;
    logic [2:0]         k;

    assign b          = i_in.in_byte;
    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && (o_job.count != 3'd0);

    // Decode the byte, update the observation state and build the result list.
    always_comb begin
        n_count   = (r_count != COUNT_SAT) ? r_count + 1'b1 : r_count;
        v_fail    = r_failed || (n_count > r_max_bytes);
        n_accum   = r_accum;
        n_left    = r_left;
        n_slen    = r_slen;
        n_psp     = r_psp;
        n_pnl     = r_pnl;
        n_emitted = r_emitted;
        n_held    = r_held;
        v_finish  = 1'b0;
        v_emit    = 1'b0;
        v_pos     = 2'd0;

        if (!v_fail) begin
            if (r_left == 2'd0) begin
                if (b[7] == 1'b0) begin
                    n_accum  = {13'd0, b};
                    n_slen   = 2'd0;
                    v_finish = 1'b1;
                end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
                    n_accum   = {16'd0, b[4:0]};
                    n_slen    = 2'd1;
                    n_left    = 2'd1;
                    n_held[0] = b;
                end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
                    n_accum   = {17'd0, b[3:0]};
                    n_slen    = 2'd2;
                    n_left    = 2'd2;
                    n_held[0] = b;
                end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
                    n_accum   = {18'd0, b[2:0]};
                    n_slen    = 2'd3;
                    n_left    = 2'd3;
                    n_held[0] = b;
                end else begin
                    v_fail = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                v_fail = 1'b1;
            end else begin
                n_accum = {r_accum[14:0], b[5:0]};
                n_left  = r_left - 1'b1;
                if (n_left == 2'd0) begin
                    v_finish = 1'b1;
                end else begin
                    v_pos = n_slen - n_left;
                    if (v_pos != 2'd3) begin
                        n_held[v_pos] = b;
                    end
                end
            end
        end

        // A complete code point is checked and classified.
        if (v_finish) begin
            if ((n_slen == 2'd1 && n_accum < 21'h80) ||
                (n_slen == 2'd2 && n_accum < 21'h800) ||
                (n_slen == 2'd3 && n_accum < 21'h10000) ||
                (n_accum > CP_MAX) ||
                (n_accum inside {[CP_SURR_LO:CP_SURR_HI]})) begin
                v_fail = 1'b1;
            end else if (n_accum == CP_CR || n_accum == CP_LF ||
                         n_accum == CP_LSEP || n_accum == CP_PSEP) begin
                n_pnl = r_emitted;
                n_psp = 1'b0;
            end else if (n_accum <= CP_SPACE ||
                         (n_accum inside {[CP_C1_LO:CP_C1_HI]}) ||
                         n_accum == CP_NBSP) begin
                n_psp = r_emitted;
            end else if (n_accum != CP_BOM) begin
                v_emit    = 1'b1;
                n_pnl     = 1'b0;
                n_psp     = 1'b0;
                n_emitted = 1'b1;
            end
        end

        // Candidate results in output order.
        cand[0]   = '{kind: KIND_DATA, out_byte: r_pnl ? BYTE_LF : BYTE_SPACE};
        cand_v[0] = v_emit && (r_pnl || r_psp);
        for (int i = 0; i < 3; i++) begin
            cand[i+1]   = '{kind: KIND_DATA, out_byte: r_held[i]};
            cand_v[i+1] = v_emit && (2'(i) < n_slen);
        end
        cand[4]   = '{kind: KIND_DATA, out_byte: b};
        cand_v[4] = v_emit;
        cand_v[5] = i_in.in_last;
        cand[5]   = '{kind: (v_fail || n_left != 2'd0) ? KIND_REJECT : KIND_ACCEPT,
                      out_byte: 8'd0};

        // Pack the present candidates to the front of the job.
        o_job = '0;
        k     = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (cand_v[i]) begin
                o_job.items[k] = cand[i];
                k = k + 3'd1;
            end
        end
        o_job.count = k;

        n_failed = v_fail;

        // The end of an observation returns its state to the start.
        if (i_in.in_last) begin
            n_count   = '0;
            n_accum   = '0;
            n_left    = 2'd0;
            n_slen    = 2'd0;
            n_psp     = 1'b0;
            n_pnl     = 1'b0;
            n_emitted = 1'b0;
            n_failed  = 1'b0;
        end
    end

    // Length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_we) begin
            r_max_bytes <= i_cfg_data;
        end
    end

    // Observation state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_accum   <= '0;
            r_left    <= 2'd0;
            r_slen    <= 2'd0;
            r_psp     <= 1'b0;
            r_pnl     <= 1'b0;
            r_emitted <= 1'b0;
            r_failed  <= 1'b0;
        end else if (accept) begin
            r_count   <= n_count;
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_slen    <= n_slen;
            r_psp     <= n_psp;
            r_pnl     <= n_pnl;
            r_emitted <= n_emitted;
            r_failed  <= n_failed;
        end
    end

    // Bytes of the sequence in progress; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

/* rtl/uvc_queue.sv */
module uvc_queue
    import uvc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_stat
);

    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_fill;
    t_job       r_mem [QUEUE_DEPTH];

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_fill == 3'(QUEUE_DEPTH));
    assign o_stat.not_empty = (r_fill != 3'd0);

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_fill   <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 3'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 3'd1;
            end
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* rtl/uvc_back.sv */
module uvc_back
    import uvc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_head,
    input  t_queue_status i_qstat,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_item     o_out
);

    logic [2:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    t_result    item;
    logic       item_last;
    logic       load;

    assign item      = i_head.items[r_idx];
    assign item_last = (r_idx == i_head.count - 3'd1);
    assign load      = i_qstat.not_empty && (!r_out_valid || i_out_ready);
    assign o_pop     = load && item_last;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Step through the head job one result per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= item_last ? 3'd0 : r_idx + 3'd1;
            end
            r_out_valid <= load || (r_out_valid && !i_out_ready);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= '{kind: item.kind, out_byte: item.out_byte, run_last: item_last};
        end
    end

endmodule

/* rtl/utf8_validate_collapse_whitespace_unit.sv */
// The results of an input byte are registered in the job queue and then in the output register.
// Throughput: one input byte per cycle while the result queue has room; the output
// register gives one result per cycle while the receiver is ready.
// A four-entry job queue absorbs bursts of up to six results from one byte.
// Reset (synchronous, active low) clears the observation state and the queue and
// sets the length limit to 4096; there is no clearing pass.
module utf8_validate_collapse_whitespace_unit
    import uvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    t_queue_status qstat;
    t_job          job;
    t_job          head;
    logic          push;
    logic          pop;

    // Decoder and classifier.
    uvc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (job)
    );

    // Job queue between the two halves.
    uvc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Result serialiser.
    uvc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/uvc_checker.sv */
module uvc_checker
    import uvc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // A status result carries a zero byte and always ends its run.
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind != KIND_DATA) |-> (o_out.out_byte == 8'd0 && o_out.run_last))
        else $error("status result with data byte or without run end");

    // Only the three defined kinds appear.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.kind == KIND_DATA || o_out.kind == KIND_ACCEPT ||
                         o_out.kind == KIND_REJECT))
        else $error("undefined result kind");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    // Nothing is offered straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind utf8_validate_collapse_whitespace_unit uvc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

/* test/tb_top.sv */
module tb_top;
    import uvc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 4;
    localparam int TAIL_CYCLES = 10;

    // Length limit used to probe both sides of the boundary.
    localparam logic [COUNT_W-1:0] LIMIT_PROBE = 13'd40;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out;

    utf8_validate_collapse_whitespace_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Predicted decoder state, mirrored from the block's behaviour.
    logic [COUNT_W-1:0] limit_bytes;
    logic [7:0]         seq_bytes [3];
    logic [20:0]        code_point;
    logic [1:0]         cont_left;
    logic [1:0]         cont_total;
    bit                 space_waiting;
    bit                 newline_waiting;
    bit                 text_started;
    bit                 obs_bad;
    logic [COUNT_W-1:0] obs_length;

    // Normalised output still owed by the block, oldest first.
    t_out_item normalized_q [$];
    t_out_item step_results [$];
    t_out_item oldest_output;

    // Bytes of the observation about to be sent.
    logic [7:0] obs_bytes [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  hold_left     = 0;
    int  cycle_count   = 0;
    int  mismatches    = 0;
    int  results_seen  = 0;
    int  decoded_bytes = 0;
    int  accepted_obs  = 0;
    int  rejected_obs  = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Return the decoder to its idle state between observations.
    function automatic void clear_observation();
        seq_bytes[0]    = '0;
        seq_bytes[1]    = '0;
        seq_bytes[2]    = '0;
        code_point      = '0;
        cont_left       = '0;
        cont_total      = '0;
        space_waiting   = 1'b0;
        newline_waiting = 1'b0;
        text_started    = 1'b0;
        obs_bad         = 1'b0;
        obs_length      = '0;
    endfunction

    // Append one byte to the observation being built.
    function automatic void add_obs_byte(input logic [7:0] value);
        obs_bytes.insert(obs_bytes.size(), value);
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] value);
        t_out_item r;
        r.kind     = kind;
        r.out_byte = value;
        r.run_last = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    // A code point has just been completed by final_byte; classify and emit it.
    function automatic void complete_code_point(input logic [7:0] final_byte);
        logic [20:0] c;
        int          i;
        c = code_point;
        if ((cont_total == 2'd1 && c < 21'h80) || (cont_total == 2'd2 && c < 21'h800) ||
            (cont_total == 2'd3 && c < 21'h10000) || c > CP_MAX ||
            (c >= CP_SURR_LO && c <= CP_SURR_HI)) begin
            obs_bad = 1'b1;
        end else if (c == CP_CR || c == CP_LF || c == CP_LSEP || c == CP_PSEP) begin
            newline_waiting = text_started;
            space_waiting   = 1'b0;
        end else if (c <= CP_SPACE || (c >= CP_C1_LO && c <= CP_C1_HI) || c == CP_NBSP) begin
            space_waiting = text_started;
        end else if (c != CP_BOM) begin
            // A visible character: the waiting separator goes first, newline winning.
            if (newline_waiting) begin
                emit(KIND_DATA, BYTE_LF);
            end else if (space_waiting) begin
                emit(KIND_DATA, BYTE_SPACE);
            end
            newline_waiting = 1'b0;
            space_waiting   = 1'b0;
            for (i = 0; i < 3; i++) begin
                if (i < int'(cont_total)) begin
                    emit(KIND_DATA, seq_bytes[i]);
                end
            end
            emit(KIND_DATA, final_byte);
            text_started = 1'b1;
        end
    endfunction

    // Work out the results of one transferred byte and queue them.
    function automatic void decode_utf8_byte(input logic [7:0] b, input logic last);
        int        i;
        t_out_item r;
        step_results.delete();
        if (obs_length != COUNT_SAT) begin
            obs_length = obs_length + 1'b1;
        end
        if (obs_length > limit_bytes) begin
            obs_bad = 1'b1;
        end
        decoded_bytes++;

        if (!obs_bad) begin
            if (cont_left == 2'd0) begin
                if (b < 8'h80) begin
                    code_point = {13'd0, b};
                    cont_total = 2'd0;
                    complete_code_point(b);
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    code_point   = {16'd0, b[4:0]};
                    cont_total   = 2'd1;
                    cont_left    = 2'd1;
                    seq_bytes[0] = b;
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    code_point   = {17'd0, b[3:0]};
                    cont_total   = 2'd2;
                    cont_left    = 2'd2;
                    seq_bytes[0] = b;
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    code_point   = {18'd0, b[2:0]};
                    cont_total   = 2'd3;
                    cont_left    = 2'd3;
                    seq_bytes[0] = b;
                end else begin
                    obs_bad = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                obs_bad = 1'b1;
            end else begin
                code_point = {code_point[14:0], b[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    complete_code_point(b);
                end else begin
                    seq_bytes[cont_total - cont_left] = b;
                end
            end
        end

        // The final byte always reports the verdict and clears the observation.
        if (last) begin
            if (cont_left != 2'd0) begin
                obs_bad = 1'b1;
            end
            emit(obs_bad ? KIND_REJECT : KIND_ACCEPT, 8'h00);
            if (obs_bad) begin
                rejected_obs++;
            end else begin
                accepted_obs++;
            end
            clear_observation();
        end

        for (i = 0; i < step_results.size(); i++) begin
            r          = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            normalized_q.insert(normalized_q.size(), r);
        end
    endfunction

    // Append a code point encoded in len bytes; short values give overlong forms.
    function automatic void push_encoded(input logic [20:0] cp, input int len);
        case (len)
            1: begin
                add_obs_byte({1'b0, cp[6:0]});
            end
            2: begin
                add_obs_byte({3'b110, cp[10:6]});
                add_obs_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_obs_byte({4'b1110, cp[15:12]});
                add_obs_byte({2'b10, cp[11:6]});
                add_obs_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_obs_byte({5'b11110, cp[20:18]});
                add_obs_byte({2'b10, cp[17:12]});
                add_obs_byte({2'b10, cp[11:6]});
                add_obs_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // One well-formed character, weighted towards the separators and specials.
    function automatic void push_valid_unit();
        int unsigned pick;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 35) begin
            push_encoded(21'($urandom_range(8'h21, 8'h7e)), 1);
        end else if (pick < 45) begin
            cp = ($urandom_range(3) == 0) ? CP_C1_LO : 21'($urandom_range(0, 32));
            push_encoded(cp, 1);
        end else if (pick < 52) begin
            push_encoded(($urandom_range(1) == 1) ? CP_CR : CP_LF, 1);
        end else if (pick < 67) begin
            if ($urandom_range(1) == 1) begin
                cp = 21'($urandom_range(32'h80, 32'ha0));
            end else begin
                cp = 21'($urandom_range(32'ha1, 32'h7ff));
            end
            push_encoded(cp, 2);
        end else if (pick < 85) begin
            case ($urandom_range(7))
                0:       cp = CP_LSEP;
                1:       cp = CP_PSEP;
                2:       cp = CP_BOM;
                default: begin
                    // Skip over the surrogate block.
                    cp = 21'($urandom_range(32'h800, 32'hf7ff));
                    if (cp >= CP_SURR_LO) begin
                        cp = cp + 21'h800;
                    end
                end
            endcase
            push_encoded(cp, 3);
        end else begin
            cp = ($urandom_range(7) == 0) ? CP_MAX : 21'($urandom_range(32'h10000, 32'h10ffff));
            push_encoded(cp, 4);
        end
    endfunction

    // One malformed sequence of a random sort.
    function automatic void push_broken_unit();
        logic [7:0] b;
        case ($urandom_range(5))
            0: push_encoded(21'($urandom_range(0, 32'h7f)), 2);
            1: push_encoded(21'($urandom_range(0, 32'h7ff)), 3);
            2: push_encoded(21'($urandom_range(0, 32'hffff)), 4);
            3: push_encoded(21'($urandom_range(32'hd800, 32'hdfff)), 3);
            4: push_encoded(21'($urandom_range(32'h110000, 32'h1fffff)), 4);
            default: begin
                // A valid lead byte followed by something that is not a continuation.
                add_obs_byte(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10) begin
                    b[6] = 1'b1;
                end
                add_obs_byte(b);
            end
        endcase
    endfunction

    // Mostly well-formed text, some with one bad sequence, a cut-off tail or pure noise.
    function automatic void build_random_observation();
        int unsigned flavour;
        int unsigned units;
        int unsigned bad_at;
        int unsigned i;
        obs_bytes.delete();
        flavour = $urandom_range(9);
        units   = $urandom_range(1, 8);
        if (flavour == 0) begin
            for (i = 0; i < units; i++) begin
                add_obs_byte(8'($urandom_range(255)));
            end
        end else begin
            bad_at = $urandom_range(units - 1);
            for (i = 0; i < units; i++) begin
                if (flavour == 1 && i == bad_at) begin
                    push_broken_unit();
                end else begin
                    push_valid_unit();
                end
            end
            if (flavour == 2) begin
                push_encoded(21'($urandom_range(32'h10000, 32'h10ffff)), 4);
                repeat ($urandom_range(1, 3)) void'(obs_bytes.pop_back());
            end
        end
    endfunction

    // Offer one byte, hold it until the transfer, then predict its results.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item item;
        int       gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.in_byte = b;
        item.in_last = last;
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_utf8_byte(b, last);
    endtask

    task automatic send_observation();
        int i;
        for (i = 0; i < obs_bytes.size(); i++) begin
            send_byte(obs_bytes[i], i == obs_bytes.size() - 1);
        end
    endtask

    // Stop offering and wait for every predicted result to come out.
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (normalized_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_bytes(input logic [COUNT_W-1:0] value);
        drain_outputs();
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_bytes = value;
    endtask

    // Separators, leading and trailing drops, and the longest legal sequences.
    task automatic test_visible_text();
        obs_bytes = '{8'h41, 8'h0a};
        send_observation();
        obs_bytes = '{8'h00, 8'h41, 8'h20, 8'h0d, 8'h7e};
        send_observation();
        obs_bytes = '{8'hc2, 8'h85, 8'h5a, 8'hc2, 8'ha0, 8'hdf, 8'hbf};
        send_observation();
        obs_bytes = '{8'hef, 8'hbb, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_observation();
    endtask

    // Surrogate, bad lead, beyond U+10FFFF, bad continuation and a cut-off sequence.
    task automatic test_malformed();
        obs_bytes = '{8'hed, 8'ha0, 8'h80};
        send_observation();
        obs_bytes = '{8'hff};
        send_observation();
        obs_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
        send_observation();
        obs_bytes = '{8'hc3, 8'h41};
        send_observation();
        obs_bytes = '{8'hc3};
        send_observation();
    endtask

    task automatic test_random_text(input int target);
        int stop_at;
        stop_at = decoded_bytes + target;
        while (decoded_bytes < stop_at) begin
            build_random_observation();
            send_observation();
        end
    endtask

    // The receiver stops for a long stretch while a dense observation keeps coming.
    task automatic test_backpressure();
        int i;
        obs_bytes.delete();
        for (i = 0; i < 24; i++) begin
            push_valid_unit();
        end
        hold_req = 1'b1;
        send_observation();
    endtask

    // Observations exactly at and one byte over the length limit.
    task automatic test_length_limit();
        int i;
        write_max_bytes(13'd1);
        obs_bytes = '{8'h41};
        send_observation();
        obs_bytes = '{8'h42, 8'h43};
        send_observation();
        write_max_bytes(LIMIT_PROBE);
        obs_bytes.delete();
        for (i = 0; i < int'(LIMIT_PROBE); i++) begin
            add_obs_byte(BYTE_SPACE);
        end
        send_observation();
        add_obs_byte(BYTE_SPACE);
        send_observation();
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normalized_q.size() == 0) begin
                $display("%0t: unexpected result, kind %0d byte %02h run_last %0b",
                         $time, o_out.kind, o_out.out_byte, o_out.run_last);
                mismatches++;
            end else begin
                oldest_output = normalized_q.pop_front();
                results_seen++;
                if (o_out.kind !== oldest_output.kind) begin
                    $display("%0t: kind expected %0d, got %0d",
                             $time, oldest_output.kind, o_out.kind);
                    mismatches++;
                end
                if (o_out.out_byte !== oldest_output.out_byte) begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, oldest_output.out_byte, o_out.out_byte);
                    mismatches++;
                end
                if (o_out.run_last !== oldest_output.run_last) begin
                    $display("%0t: run_last expected %0b, got %0b",
                             $time, oldest_output.run_last, o_out.run_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, normalized_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in       = '0;
        clear_observation();
        limit_bytes = MAX_BYTES_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_max_bytes(MAX_BYTES_RST);

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 21;
        recv_idle_pct = 57;
        test_visible_text();
        test_malformed();
        test_random_text(120);

        // Roles swapped, with a tight length limit.
        drain_outputs();
        send_idle_pct = 57;
        recv_idle_pct = 21;
        write_max_bytes(13'd12);
        test_random_text(120);
        write_max_bytes(MAX_BYTES_RST);
        test_backpressure();

        // No idling on either side.
        drain_outputs();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_length_limit();
        write_max_bytes(13'($urandom_range(20, 64)));
        test_random_text(120);

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results from %0d bytes, %0d observations accepted, %0d rejected.",
                 results_seen, decoded_bytes, accepted_obs, rejected_obs);
        $display("Covered separators, malformed and cut-off text, length limits and a long stall.");
        if (mismatches == 0 && normalized_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
